// ===== hdl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg: shared types, letter codes and key-square lookup
// Holds the key-square types, the fixed letter codes and the functions that
// locate letters in the square and encipher one digraph.
// ----------------------------------------------------------------------------
package pfde_pkg;

   // Geometry of the key square
   localparam int SIDE      = 5;
   localparam int LETTER_W  = 5;
   localparam int ROW_W     = SIDE * LETTER_W;
   localparam int IDX_W     = 3;
   localparam int CSR_IDX_W = 3;

   typedef logic [LETTER_W-1:0]         letter_type;
   typedef logic [IDX_W-1:0]            idx_type;
   typedef logic [ROW_W-1:0]            row_type;
   typedef logic [SIDE-1:0][ROW_W-1:0]  square_type;

   typedef struct packed {
      idx_type row;
      idx_type col;
   } pos_type;

   typedef struct packed {
      letter_type first;
      letter_type second;
   } pair_type;

   // Letter codes with special meaning
   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_X = 5'd23;
   localparam letter_type LETTER_Z = 5'd25;

   // Key square after reset: a..z without j, row by row
   localparam square_type SQUARE_RESET = {25'd27025109, 25'd21613104, 25'd16201099,
                                          25'd10755269, 25'd4294688};

   // Last row or column index before wrapping
   localparam idx_type IDX_LAST = idx_type'(SIDE - 1);

   // Entry at a row and column of the square.
   function automatic letter_type sq_get(square_type sq, idx_type r, idx_type c);
      row_type    row;
      letter_type ent;
      row = sq[r];
      case (c)
         3'd0:    ent = row[4:0];
         3'd1:    ent = row[9:5];
         3'd2:    ent = row[14:10];
         3'd3:    ent = row[19:15];
         default: ent = row[24:20];
      endcase
      return ent;
   endfunction

   // Next index with wrap-around.
   function automatic idx_type idx_next(idx_type i);
      return (i == IDX_LAST) ? idx_type'(0) : idx_type'(i + idx_type'(1));
   endfunction

   // Position of a letter; the first match in row-major order wins and a letter
   // that is not in the square maps to row 0, column 0.
   function automatic pos_type sq_find(square_type sq, letter_type l);
      pos_type p;
      logic    found;
      p     = '0;
      found = 1'b0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            if (!found && sq[r][c*LETTER_W +: LETTER_W] == l) begin
               found = 1'b1;
               p.row = idx_type'(r);
               p.col = idx_type'(c);
            end
         end
      end
      return p;
   endfunction

   // Enciphers one digraph with the row, column and rectangle rules.
   function automatic pair_type encipher(square_type sq, letter_type a, letter_type b);
      pos_type  pa;
      pos_type  pb;
      pair_type res;
      pa = sq_find(sq, a);
      pb = sq_find(sq, b);
      if (pa.row == pb.row) begin
         res.first  = sq_get(sq, pa.row, idx_next(pa.col));
         res.second = sq_get(sq, pb.row, idx_next(pb.col));
      end else if (pa.col == pb.col) begin
         res.first  = sq_get(sq, idx_next(pa.row), pa.col);
         res.second = sq_get(sq, idx_next(pb.row), pb.col);
      end else begin
         res.first  = sq_get(sq, pa.row, pb.col);
         res.second = sq_get(sq, pb.row, pa.col);
      end
      return res;
   endfunction

endpackage

// ===== hdl/playfair_digraph_encryptor_top.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor_top: streaming Playfair digraph encryptor
// Pairs plaintext letters, inserts fillers and pads, and enciphers each
// digraph through a 5x5 key square held in five row registers.
// ----------------------------------------------------------------------------
// Usage:
// Letters enter on the req_ channel, one per transfer; req_tlast marks the
// last letter of a message. Enciphered letters leave on the rsp_ channel;
// rsp_tlast marks the last result caused by one input letter.
// A letter is registered in the input register at its input transfer; from
// there its results (none, two or four) are formed combinationally by the
// pairing and lookup logic and placed in a four-entry result buffer once that
// buffer is free. The first result is presented on rsp_ from the result buffer.
// A letter that only opens a pair passes the input register even while the
// buffer drains. A letter that releases results waits until the last
// buffered result leaves. The output side moves one letter per cycle while
// rsp_tready is high; a doubled pair with an end pad releases four results.
// The output port sets the sustained rate.
// When the receiver stalls, the buffer holds its results and the input
// register holds one further result-releasing letter before req_tready drops.
// Reset clears the held letter, both buffers and restores the alphabetical key square.
// The user writes the square through csr_ while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module playfair_digraph_encryptor_top (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [4:0] plain_letter, [7:5] zero
   input  logic                            req_tlast,  // end_of_text
   // Result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // [4:0] cipher_letter, [7:5] zero
   output logic                            rsp_tlast,  // last_of_run
   // Key square write port
   input  logic                            csr_wr_en,
   input  logic [pfde_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfde_pkg::ROW_W-1:0]      csr_wdata
);
   import pfde_pkg::*;

   // Key square rows
   square_type square_ff, square_in;

   // Input register
   logic       in_valid_ff, in_valid_in;
   letter_type in_letter_ff, in_letter_in;
   logic       in_eot_ff, in_eot_in;

   // Pairing state
   logic       held_valid_ff, held_valid_in;
   letter_type held_letter_ff, held_letter_in;

   // Result buffer
   letter_type res_ff [4];
   letter_type res_in [4];
   logic [2:0] res_cnt_ff, res_cnt_in;
   logic [2:0] res_idx_ff, res_idx_in;

   logic       load;
   logic       emit;
   logic       buf_free;
   logic       rsp_fire;
   logic       req_fire;
   letter_type letter;
   letter_type filler;
   letter_type pad;
   letter_type partner;
   logic       doubled;
   logic       alone;
   logic       pad_now;
   pair_type   pair_a;
   pair_type   pair_b;

   // Handshakes; a letter that releases no results never touches the buffer.
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_fire = req_tvalid && req_tready;
   assign emit     = held_valid_ff || in_eot_ff;
   assign buf_free = (res_idx_ff == res_cnt_ff) ||
                     (rsp_fire && (res_idx_ff == res_cnt_ff - 3'd1));
   assign load       = in_valid_ff && (!emit || buf_free);
   assign req_tready = !in_valid_ff || load;

   // Pairing decisions for the registered letter
   always_comb begin
      letter  = (in_letter_ff == LETTER_J) ? LETTER_I : in_letter_ff;
      filler  = (held_letter_ff == LETTER_X) ? LETTER_Z : LETTER_X;
      pad     = (letter == LETTER_Z) ? LETTER_X : LETTER_Z;
      doubled = held_valid_ff && (held_letter_ff == letter);
      partner = doubled ? filler : letter;
      alone   = !held_valid_ff || doubled;
      pad_now = alone && in_eot_ff;
      pair_a  = encipher(square_ff, held_letter_ff, partner);
      pair_b  = encipher(square_ff, letter, pad);
   end

   // Next state of the input register, pairing state and result buffer
   always_comb begin
      in_valid_in    = in_valid_ff;
      in_letter_in   = in_letter_ff;
      in_eot_in      = in_eot_ff;
      held_valid_in  = held_valid_ff;
      held_letter_in = held_letter_ff;
      res_in         = res_ff;
      res_cnt_in     = res_cnt_ff;
      res_idx_in     = res_idx_ff;

      if (rsp_fire) begin
         res_idx_in = res_idx_ff + 3'd1;
      end

      if (load) begin
         in_valid_in = 1'b0;
         if (emit) begin
            res_idx_in = 3'd0;
            if (held_valid_ff) begin
               res_in[0] = pair_a.first;
               res_in[1] = pair_a.second;
               res_in[2] = pair_b.first;
               res_in[3] = pair_b.second;
               res_cnt_in = pad_now ? 3'd4 : 3'd2;
            end else begin
               res_in[0] = pair_b.first;
               res_in[1] = pair_b.second;
               res_cnt_in = pad_now ? 3'd2 : 3'd0;
            end
         end
         if (alone && !in_eot_ff) begin
            held_valid_in  = 1'b1;
            held_letter_in = letter;
         end else begin
            held_valid_in  = 1'b0;
            held_letter_in = '0;
         end
      end

      if (req_fire) begin
         in_valid_in  = 1'b1;
         in_letter_in = req_tdata[LETTER_W-1:0];
         in_eot_in    = req_tlast;
      end
   end

   // Key square writes; indexes beyond the last row are ignored
   always_comb begin
      square_in = square_ff;
      if (csr_wr_en && (csr_index < CSR_IDX_W'(SIDE))) begin
         square_in[csr_index] = csr_wdata;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         square_ff      <= SQUARE_RESET;
         in_valid_ff    <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_letter_ff <= '0;
         res_cnt_ff     <= 3'd0;
         res_idx_ff     <= 3'd0;
      end else begin
         square_ff      <= square_in;
         in_valid_ff    <= in_valid_in;
         held_valid_ff  <= held_valid_in;
         held_letter_ff <= held_letter_in;
         res_cnt_ff     <= res_cnt_in;
         res_idx_ff     <= res_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_letter_ff <= in_letter_in;
      in_eot_ff    <= in_eot_in;
      res_ff       <= res_in;
   end

   // Result port
   assign rsp_tvalid = (res_idx_ff != res_cnt_ff);
   assign rsp_tdata  = {3'b000, res_ff[res_idx_ff[1:0]]};
   assign rsp_tlast  = (res_idx_ff == res_cnt_ff - 3'd1);

   // The buffer only ever holds whole digraphs.
   assert property (@(posedge clock) disable iff (reset)
      (res_cnt_ff == 3'd0) || (res_cnt_ff == 3'd2) || (res_cnt_ff == 3'd4))
      else $error("result count is not a whole number of digraphs");

   // The read index never passes the fill count.
   assert property (@(posedge clock) disable iff (reset)
      res_idx_ff <= res_cnt_ff)
      else $error("result read index beyond fill count");

   // The end of a message always leaves no letter held.
   assert property (@(posedge clock) disable iff (reset)
      load && in_eot_ff |=> !held_valid_ff)
      else $error("letter still held after end of text");

   // A result-releasing letter only fills an empty or draining buffer.
   assert property (@(posedge clock) disable iff (reset)
      load && emit && rsp_tvalid |-> rsp_tready && rsp_tlast)
      else $error("buffer overwritten before its last result was taken");

endmodule
